// File: rtl/core/cmsl_pkg.sv
// Shared types, codes and constants of the CAN monitor-and-control slave.
package cmsl_pkg;

   // widths fixed by the frame and register formats
   localparam int FUNC_W        = 2;
   localparam int CAN_ID_W      = 29;
   localparam int DATA_LEN_W    = 4;
   localparam int PAYLOAD_W     = 64;
   localparam int STATUS_W      = 16;
   localparam int ACTION_W      = 3;
   localparam int HANDLER_W     = 3;
   localparam int REL_W         = 18;
   localparam int NODE_W        = 6;
   localparam int RANGE_COUNT_W = 3;
   localparam int RANGE_W       = 2 * REL_W;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = RANGE_W;

   // defaults for top-level parameters
   localparam int MAX_RANGES_DEFAULT = 6;

   // node window: base = (node + 1) << NODE_SHIFT
   localparam int NODE_SHIFT = REL_W;
   localparam int BASE_HI_W  = CAN_ID_W - NODE_SHIFT;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_ID     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_COUNT = 3'd1;
   localparam int                     CSR_RANGE_BASE  = 2;

   // relative addresses with fixed meaning
   localparam logic [REL_W-1:0] REL_SERIAL    = 18'h00000;
   localparam logic [REL_W-1:0] REL_PROTO_REV = 18'h30000;
   localparam logic [REL_W-1:0] REL_ERR_COUNT = 18'h30001;
   localparam logic [REL_W-1:0] REL_TXN_COUNT = 18'h30002;
   localparam logic [REL_W-1:0] REL_SW_REV    = 18'h30004;
   localparam logic [REL_W-1:0] REL_HW_REV    = 18'h30005;
   localparam logic [REL_W-1:0] REL_RESET_A   = 18'h31000;
   localparam logic [REL_W-1:0] REL_RESET_B   = 18'h31001;

   // revision replies, byte 0 in bits 7:0
   localparam logic [PAYLOAD_W-1:0] PROTO_REV_DATA = 64'h020101;
   localparam logic [PAYLOAD_W-1:0] SW_REV_DATA    = 64'h030201;
   localparam logic [PAYLOAD_W-1:0] HW_REV_DATA    = 64'h0601;

   // status word bits
   localparam int ST_BUS_OFF  = 15;
   localparam int ST_WARNING  = 14;
   localparam int ST_TX_OK    = 11;
   localparam int ST_CODE_LSB = 8;
   localparam int ST_CODE_W   = 3;
   localparam logic [ST_CODE_W-1:0] CODE_NONE  = 3'd0;
   localparam logic [ST_CODE_W-1:0] CODE_BIT0  = 3'd4;
   localparam logic [ST_CODE_W-1:0] CODE_UNUSED = 3'd7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_REQUEST  = 2'd0,
      FUNC_IDENTIFY = 2'd1,
      FUNC_STATUS   = 2'd2
   } func_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE     = 3'd0,
      ACT_SERIAL   = 3'd1,
      ACT_BUILTIN  = 3'd2,
      ACT_DISPATCH = 3'd3,
      ACT_RESET    = 3'd4
   } action_type;

   typedef struct packed {
      logic [FUNC_W-1:0]     func;
      logic [CAN_ID_W-1:0]   can_id;
      logic [DATA_LEN_W-1:0] data_len;
      logic [PAYLOAD_W-1:0]  payload;
      logic                  msg_lost;
      logic [STATUS_W-1:0]   status_word;
   } req_word_type;

   typedef struct packed {
      action_type            action;
      logic [HANDLER_W-1:0]  handler_index;
      logic                  is_monitor;
      logic [REL_W-1:0]      rel_address;
      logic [CAN_ID_W-1:0]   reply_id;
      logic [DATA_LEN_W-1:0] reply_len;
      logic [PAYLOAD_W-1:0]  reply_data;
   } rsp_word_type;

   // handshake between the input stage and the engine
   typedef struct packed {
      logic valid;
   } stage_ctl_type;

   typedef struct packed {
      logic take;
   } stage_ack_type;

   typedef struct packed {
      logic [NODE_W-1:0]        node_id;
      logic [RANGE_COUNT_W-1:0] range_count;
   } cfg_base_type;

endpackage

// File: rtl/core/cmsl_if.sv
// Channel interfaces: request words in, response words out.
interface cmsl_req_if import cmsl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [CAN_ID_W-1:0]   can_id;
   logic [DATA_LEN_W-1:0] data_len;
   logic [PAYLOAD_W-1:0]  payload;
   logic                  msg_lost;
   logic [STATUS_W-1:0]   status_word;

   modport source (output valid, func, can_id, data_len, payload, msg_lost, status_word,
                   input ready);
   modport sink   (input valid, func, can_id, data_len, payload, msg_lost, status_word,
                   output ready);
endinterface

interface cmsl_rsp_if import cmsl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   action_type            action;
   logic [HANDLER_W-1:0]  handler_index;
   logic                  is_monitor;
   logic [REL_W-1:0]      rel_address;
   logic [CAN_ID_W-1:0]   reply_id;
   logic [DATA_LEN_W-1:0] reply_len;
   logic [PAYLOAD_W-1:0]  reply_data;

   modport source (output valid, action, handler_index, is_monitor, rel_address, reply_id,
                   reply_len, reply_data, input ready);
   modport sink   (input valid, action, handler_index, is_monitor, rel_address, reply_id,
                   reply_len, reply_data, output ready);
endinterface

// File: rtl/core/cmsl_csr.sv
// Configuration registers: node number, range count and handler ranges.
module cmsl_csr import cmsl_pkg::*; #(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_base_type           cfg_base,
   output logic [RANGE_W-1:0]     ranges [MAX_RANGES]
);

   logic [NODE_W-1:0]        node_ff;
   logic [RANGE_COUNT_W-1:0] count_ff;
   logic [RANGE_W-1:0]       range_ff [MAX_RANGES];

   // scalar registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff  <= '0;
         count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NODE_ID:     node_ff  <= csr_wdata[NODE_W-1:0];
            CSR_RANGE_COUNT: count_ff <= csr_wdata[RANGE_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // handler ranges; indexes past the last range are dropped
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RANGES; i++) begin
         if (reset) begin
            range_ff[i] <= '0;
         end else if (csr_we && csr_index == CSR_INDEX_W'(CSR_RANGE_BASE + i)) begin
            range_ff[i] <= csr_wdata[RANGE_W-1:0];
         end
      end
   end

   assign cfg_base.node_id     = node_ff;
   assign cfg_base.range_count = count_ff;
   assign ranges               = range_ff;

endmodule

// File: rtl/core/cmsl_in_stage.sv
// Input register: holds one request word until the engine takes it.
module cmsl_in_stage import cmsl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_word_type  req_word,
   output stage_ctl_type ctl,
   input  stage_ack_type ack,
   output req_word_type  word
);

   logic         valid_ff, valid_in;
   req_word_type word_ff;
   logic         accept;

   // free when empty or emptied this cycle
   assign req_ready = !valid_ff || ack.take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept)        valid_in = 1'b1;
      else if (ack.take) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) word_ff <= req_word;
   end

   assign ctl.valid = valid_ff;
   assign word      = word_ff;

endmodule

// File: rtl/core/cmsl_engine.sv
// Event decode, range match, counters and the response register.
module cmsl_engine import cmsl_pkg::*; #(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  stage_ctl_type      ctl,
   output stage_ack_type      ack,
   input  req_word_type       word,
   input  cfg_base_type       cfg_base,
   input  logic [RANGE_W-1:0] ranges [MAX_RANGES],
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_word_type       rsp_word
);

   // state
   logic [15:0] err_ff, err_in;
   logic [31:0] txn_ff, txn_in;
   logic        ident_ff, ident_in;
   logic        dup_ff, dup_in;
   logic [7:0]  lsh_ff, lsh_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic take;

   // window decode
   logic [NODE_W:0]           base_hi;
   logic [CAN_ID_W-1:0]       base;
   logic                      in_window;
   logic [REL_W-1:0]          rel;
   logic                      is_mon;
   logic [15:0]               err_req;

   // built-in monitor points
   logic                      bi_hit;
   logic [DATA_LEN_W-1:0]     bi_len;
   logic [PAYLOAD_W-1:0]      bi_data;

   // range match
   logic [RANGE_COUNT_W-1:0]  count_sat;
   logic                      rng_hit;
   logic [HANDLER_W-1:0]      rng_idx;
   logic [DATA_LEN_W-1:0]     ctl_len;
   logic [PAYLOAD_W-1:0]      ctl_data;

   // status decode
   logic [ST_CODE_W-1:0]      code;
   logic                      code_err;
   logic                      ident_clr;

   assign take = ctl.valid && (!rsp_valid_ff || rsp_ready);
   assign ack.take = take;

   // base and relative address; base + rel is the identifier itself
   assign base_hi   = {1'b0, cfg_base.node_id} + (NODE_W + 1)'(1);
   assign base      = {(BASE_HI_W)'(base_hi), (NODE_SHIFT)'(0)};
   assign in_window = word.can_id[CAN_ID_W-1:NODE_SHIFT] == (BASE_HI_W)'(base_hi);
   assign rel       = word.can_id[REL_W-1:0];
   assign is_mon    = word.data_len == '0;
   assign err_req   = err_ff + 16'(word.msg_lost);

   // built-in replies; error readback sees this word's lost-frame count
   always_comb begin
      bi_hit  = 1'b1;
      bi_len  = '0;
      bi_data = '0;
      case (rel)
         REL_PROTO_REV: begin bi_len = 4'd3; bi_data = PROTO_REV_DATA; end
         REL_SW_REV:    begin bi_len = 4'd3; bi_data = SW_REV_DATA; end
         REL_HW_REV:    begin bi_len = 4'd2; bi_data = HW_REV_DATA; end
         REL_ERR_COUNT: begin
            bi_len  = 4'd4;
            bi_data = PAYLOAD_W'({lsh_ff, 8'h00, err_req[7:0], err_req[15:8]});
         end
         REL_TXN_COUNT: begin
            bi_len  = 4'd4;
            bi_data = PAYLOAD_W'({txn_ff[7:0], txn_ff[15:8], txn_ff[23:16], txn_ff[31:24]});
         end
         default: bi_hit = 1'b0;
      endcase
   end

   // first matching range among those in use
   assign count_sat = (cfg_base.range_count > RANGE_COUNT_W'(MAX_RANGES))
                    ? RANGE_COUNT_W'(MAX_RANGES) : cfg_base.range_count;

   always_comb begin
      rng_hit = 1'b0;
      rng_idx = '0;
      for (int i = 0; i < MAX_RANGES; i++) begin
         if (!rng_hit && RANGE_COUNT_W'(i) < count_sat
             && rel >= ranges[i][REL_W-1:0] && rel <= ranges[i][RANGE_W-1:REL_W]) begin
            rng_hit = 1'b1;
            rng_idx = HANDLER_W'(i);
         end
      end
   end

   // control payload cut to at most eight bytes
   assign ctl_len = (word.data_len > 4'd8) ? 4'd8 : word.data_len;

   always_comb begin
      for (int b = 0; b < PAYLOAD_W / 8; b++) begin
         ctl_data[8*b +: 8] = (DATA_LEN_W'(b) < ctl_len) ? word.payload[8*b +: 8] : 8'h00;
      end
   end

   // status word fields
   assign code      = word.status_word[ST_CODE_LSB +: ST_CODE_W];
   assign code_err  = code != CODE_NONE && code != CODE_UNUSED;
   assign ident_clr = word.status_word[ST_TX_OK];

   // next state and response
   always_comb begin
      err_in      = err_ff;
      txn_in      = txn_ff;
      ident_in    = ident_ff;
      dup_in      = dup_ff;
      lsh_in      = lsh_ff;
      rsp_word_in = '0;
      case (word.func)
         FUNC_REQUEST: begin
            err_in = err_req;
            if (!dup_ff && in_window) begin
               if (!is_mon && (rel == REL_RESET_A || rel == REL_RESET_B)) begin
                  rsp_word_in.action      = ACT_RESET;
                  rsp_word_in.rel_address = rel;
                  rsp_word_in.reply_id    = word.can_id;
               end else if (is_mon && rel == REL_SERIAL) begin
                  ident_in               = 1'b1;
                  txn_in                 = txn_ff + 32'd1;
                  rsp_word_in.action     = ACT_SERIAL;
                  rsp_word_in.reply_id   = base;
               end else if (is_mon && bi_hit) begin
                  txn_in                  = txn_ff + 32'd1;
                  rsp_word_in.action      = ACT_BUILTIN;
                  rsp_word_in.is_monitor  = 1'b1;
                  rsp_word_in.rel_address = rel;
                  rsp_word_in.reply_id    = word.can_id;
                  rsp_word_in.reply_len   = bi_len;
                  rsp_word_in.reply_data  = bi_data;
               end else if (rng_hit) begin
                  txn_in                    = txn_ff + 32'd1;
                  rsp_word_in.action        = ACT_DISPATCH;
                  rsp_word_in.handler_index = rng_idx;
                  rsp_word_in.is_monitor    = is_mon;
                  rsp_word_in.rel_address   = rel;
                  rsp_word_in.reply_id      = word.can_id;
                  rsp_word_in.reply_len     = is_mon ? '0 : ctl_len;
                  rsp_word_in.reply_data    = is_mon ? '0 : ctl_data;
               end
            end
         end
         FUNC_IDENTIFY: begin
            ident_in             = 1'b1;
            txn_in               = txn_ff + 32'd1;
            err_in               = err_req;
            rsp_word_in.action   = ACT_SERIAL;
            rsp_word_in.reply_id = base;
         end
         FUNC_STATUS: begin
            err_in = err_ff + 16'(word.status_word[ST_BUS_OFF])
                   + 16'(word.status_word[ST_WARNING]) + 16'(code_err);
            ident_in = ident_ff && !ident_clr;
            if (code == CODE_BIT0 && ident_ff && !ident_clr) dup_in = 1'b1;
            lsh_in = word.status_word[STATUS_W-1:8];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff   <= '0;
         txn_ff   <= '0;
         ident_ff <= 1'b0;
         dup_ff   <= 1'b0;
         lsh_ff   <= '0;
      end else if (take) begin
         err_ff   <= err_in;
         txn_ff   <= txn_in;
         ident_ff <= ident_in;
         dup_ff   <= dup_in;
         lsh_ff   <= lsh_in;
      end
   end

   // response register
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (take) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: rtl/core/can_monitor_control_slave_top.sv
// Top level of the CAN monitor-and-control slave.
//
//   channel    direction  width  contents
//   req_chan   in         116    event kind, identifier, length, payload, lost, status
//   rsp_chan   out        122    action, handler, monitor flag, address, id, length, data
//   csr_*      in         3+36   register index and write data
//
// One word is accepted per cycle while the response is not stalled; each word passes the
// input register, then the response register, before its response is offered. The range
// compares and counter updates sit between those two registers. A stalled response holds
// both registers, and the input side takes a new word as soon as its register moves on.
// Synchronous reset clears the counters, flags, configuration registers and valid bits;
// no clearing pass follows.
module can_monitor_control_slave_top import cmsl_pkg::*; #(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   cmsl_req_if.sink               req_chan,
   cmsl_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_base_type       cfg_base;
   logic [RANGE_W-1:0] ranges [MAX_RANGES];
   req_word_type       req_word;
   req_word_type       stage_word;
   stage_ctl_type      stage_ctl;
   stage_ack_type      stage_ack;
   rsp_word_type       rsp_word;
   logic               req_ready;
   logic               rsp_valid;

   // pack the request word
   assign req_word.func        = req_chan.func;
   assign req_word.can_id      = req_chan.can_id;
   assign req_word.data_len    = req_chan.data_len;
   assign req_word.payload     = req_chan.payload;
   assign req_word.msg_lost    = req_chan.msg_lost;
   assign req_word.status_word = req_chan.status_word;
   assign req_chan.ready       = req_ready;

   cmsl_csr #(.MAX_RANGES(MAX_RANGES)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_base  (cfg_base),
      .ranges    (ranges)
   );

   cmsl_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .ctl       (stage_ctl),
      .ack       (stage_ack),
      .word      (stage_word)
   );

   cmsl_engine #(.MAX_RANGES(MAX_RANGES)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stage_ctl),
      .ack       (stage_ack),
      .word      (stage_word),
      .cfg_base  (cfg_base),
      .ranges    (ranges),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_word  (rsp_word)
   );

   // unpack the response word
   assign rsp_chan.valid         = rsp_valid;
   assign rsp_chan.action        = rsp_word.action;
   assign rsp_chan.handler_index = rsp_word.handler_index;
   assign rsp_chan.is_monitor    = rsp_word.is_monitor;
   assign rsp_chan.rel_address   = rsp_word.rel_address;
   assign rsp_chan.reply_id      = rsp_word.reply_id;
   assign rsp_chan.reply_len     = rsp_word.reply_len;
   assign rsp_chan.reply_data    = rsp_word.reply_data;

endmodule

// File: rtl/core/cmsl_checker.sv
// Port-level checks on the response channel, bound to the top level.
module cmsl_checker import cmsl_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input action_type            rsp_action,
   input logic [HANDLER_W-1:0]  rsp_handler_index,
   input logic                  rsp_is_monitor,
   input logic [REL_W-1:0]      rsp_rel_address,
   input logic [CAN_ID_W-1:0]   rsp_reply_id,
   input logic [DATA_LEN_W-1:0] rsp_reply_len,
   input logic [PAYLOAD_W-1:0]  rsp_reply_data
);

   // a stalled response stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // an ignored word carries nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_NONE |->
         rsp_handler_index == '0 && !rsp_is_monitor && rsp_rel_address == '0
         && rsp_reply_id == '0 && rsp_reply_len == '0 && rsp_reply_data == '0)
      else $error("nonzero fields on ignored word");

   // monitor dispatch leaves the reply to the handler
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_DISPATCH && rsp_is_monitor |->
         rsp_reply_len == '0 && rsp_reply_data == '0)
      else $error("monitor dispatch carries data");

   // reset requests come only from the two reset addresses, as control writes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_RESET |->
         !rsp_is_monitor && rsp_reply_len == '0
         && (rsp_rel_address == REL_RESET_A || rsp_rel_address == REL_RESET_B))
      else $error("malformed reset request");

   // addressed replies echo the relative address in the low id bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_BUILTIN || rsp_action == ACT_DISPATCH
                    || rsp_action == ACT_RESET) |->
         rsp_reply_id[REL_W-1:0] == rsp_rel_address && rsp_reply_len <= 4'd8)
      else $error("reply id does not match relative address");

endmodule

bind can_monitor_control_slave_top cmsl_checker u_cmsl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_action        (rsp_chan.action),
   .rsp_handler_index (rsp_chan.handler_index),
   .rsp_is_monitor    (rsp_chan.is_monitor),
   .rsp_rel_address   (rsp_chan.rel_address),
   .rsp_reply_id      (rsp_chan.reply_id),
   .rsp_reply_len     (rsp_chan.reply_len),
   .rsp_reply_data    (rsp_chan.reply_data)
);

// File: dv/can_monitor_control_slave_top_tb.sv
// Self-checking testbench for the CAN monitor-and-control slave top level.
`timescale 1ns / 1ps

module can_monitor_control_slave_top_tb;
   import cmsl_pkg::*;

   localparam int MAX_RANGES = MAX_RANGES_DEFAULT;
   localparam int WINDOW     = 1 << NODE_SHIFT;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // per-phase register settings and idle percentages
   localparam int NUM_PHASES = 8;
   localparam int PHASE_NODE  [NUM_PHASES] = '{0, 63, 17, 40, 63, 0, 9, 31};
   localparam int PHASE_COUNT [NUM_PHASES] = '{6, 7, 0, 1, 3, 6, 5, 2};
   localparam int SEND_IDLE   [4] = '{0, 47, 0, 13};
   localparam int RECV_STALL  [4] = '{0, 0, 47, 13};
   localparam int WORDS_PER_PHASE = 250;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   cmsl_req_if req_if ();
   cmsl_rsp_if rsp_if ();

   can_monitor_control_slave_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // register copies used for prediction
   logic [NODE_W-1:0]        node_cfg;
   logic [RANGE_COUNT_W-1:0] range_count_cfg;
   logic [RANGE_W-1:0]       range_cfg [MAX_RANGES];

   // predicted slave state
   logic [15:0] bus_errors;
   logic [31:0] txn_total;
   logic        identify_on;
   logic        dup_latched;
   logic [7:0]  status_hi;

   req_word_type event_q [$];
   rsp_word_type expected_rsp_q [$];
   int events_in_flight = 0;
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int rsp_hold_left = 0;
   logic word_taken = 1'b0;

   task automatic report_mismatch(string msg);
      if (mismatches < 50) $display("%0t ERROR: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   function automatic logic [CAN_ID_W:0] node_base();
      return ({{(CAN_ID_W + 1 - NODE_W){1'b0}}, node_cfg} + 1'b1) << NODE_SHIFT;
   endfunction

   // work out the response word for one event and advance the slave state
   function automatic rsp_word_type predict_response(req_word_type w);
      rsp_word_type r;
      logic [CAN_ID_W:0]     base;
      logic [REL_W-1:0]      rel, lo, hi;
      logic [ST_CODE_W-1:0]  code;
      logic [DATA_LEN_W-1:0] len;
      logic [PAYLOAD_W-1:0]  data;
      logic                  mon;
      int                    n;
      r = '0;
      r.action = ACT_NONE;
      base = node_base();
      len = '0;
      data = '0;

      if (w.func == FUNC_IDENTIFY) begin
         identify_on = 1'b1;
         txn_total++;
         if (w.msg_lost) bus_errors++;
         r.action = ACT_SERIAL;
         r.reply_id = CAN_ID_W'(base);
         return r;
      end

      if (w.func == FUNC_STATUS) begin
         code = w.status_word[ST_CODE_LSB +: ST_CODE_W];
         if (w.status_word[ST_BUS_OFF]) bus_errors++;
         if (w.status_word[ST_WARNING]) bus_errors++;
         // tx ok ends identify mode before the code is looked at
         if (w.status_word[ST_TX_OK]) identify_on = 1'b0;
         if (code != CODE_NONE && code != CODE_UNUSED) begin
            bus_errors++;
            if (code == CODE_BIT0 && identify_on) dup_latched = 1'b1;
         end
         status_hi = w.status_word[STATUS_W-1 -: 8];
         return r;
      end

      if (w.func != FUNC_REQUEST) return r;

      if (w.msg_lost) bus_errors++;
      if (dup_latched) return r;
      if (w.can_id < base || w.can_id >= base + WINDOW) return r;
      rel = REL_W'(w.can_id - base);
      mon = (w.data_len == '0);

      if (!mon && (rel == REL_RESET_A || rel == REL_RESET_B)) begin
         r.action = ACT_RESET;
         r.rel_address = rel;
         r.reply_id = w.can_id;
         return r;
      end

      // built-in monitor points
      if (mon) begin
         case (rel)
            REL_SERIAL: begin
               identify_on = 1'b1;
               txn_total++;
               r.action = ACT_SERIAL;
               r.reply_id = CAN_ID_W'(base);
               return r;
            end
            REL_PROTO_REV: begin len = 4'd3; data = PROTO_REV_DATA; end
            REL_SW_REV:    begin len = 4'd3; data = SW_REV_DATA; end
            REL_HW_REV:    begin len = 4'd2; data = HW_REV_DATA; end
            REL_ERR_COUNT: begin
               len = 4'd4;
               data = {32'd0, status_hi, 8'd0, bus_errors[7:0], bus_errors[15:8]};
            end
            REL_TXN_COUNT: begin
               len = 4'd4;
               data = {32'd0, txn_total[7:0], txn_total[15:8], txn_total[23:16],
                       txn_total[31:24]};
            end
            default: ;
         endcase
         if (len != '0) begin
            txn_total++;
            r.action = ACT_BUILTIN;
            r.is_monitor = 1'b1;
            r.rel_address = rel;
            r.reply_id = w.can_id;
            r.reply_len = len;
            r.reply_data = data;
            return r;
         end
      end

      // handler ranges, first hit wins
      n = (range_count_cfg > MAX_RANGES) ? MAX_RANGES : range_count_cfg;
      for (int i = 0; i < n; i++) begin
         lo = range_cfg[i][REL_W-1:0];
         hi = range_cfg[i][RANGE_W-1:REL_W];
         if (rel >= lo && rel <= hi) begin
            txn_total++;
            r.action = ACT_DISPATCH;
            r.handler_index = HANDLER_W'(i);
            r.is_monitor = mon;
            r.rel_address = rel;
            r.reply_id = w.can_id;
            if (!mon) begin
               len = (w.data_len > 4'd8) ? 4'd8 : w.data_len;
               data = w.payload;
               if (len < 4'd8) data &= (64'd1 << (len * 8)) - 64'd1;
               r.reply_len = len;
               r.reply_data = data;
            end
            return r;
         end
      end
      return r;
   endfunction

   // register write; the predictor copy follows at once since the slave is idle
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_NODE_ID) node_cfg = value[NODE_W-1:0];
      else if (idx == CSR_RANGE_COUNT) range_count_cfg = value[RANGE_COUNT_W-1:0];
      else range_cfg[idx - CSR_RANGE_BASE] = value[RANGE_W-1:0];
   endtask

   function automatic logic [RANGE_W-1:0] make_range();
      logic [REL_W-1:0] lo, hi;
      lo = REL_W'($urandom);
      hi = REL_W'($urandom);
      case ($urandom_range(6))
         0: begin
            hi = lo + REL_W'($urandom_range(255));
            if (hi < lo) hi = '1;
         end
         1: ;                                   // random bounds, often empty
         2: begin lo = '0; hi = '1; end         // whole window
         3: begin lo = '1; hi = '1; end
         4: begin lo = '0; hi = '0; end
         5: begin
            lo = REL_W'($urandom_range(4095));
            hi = lo + REL_W'($urandom_range(65535));
         end
         default: begin lo = 18'h30000; hi = 18'h31fff; end  // overlaps the built-ins
      endcase
      return {hi, lo};
   endfunction

   task automatic configure(logic [NODE_W-1:0] node, logic [RANGE_COUNT_W-1:0] count);
      write_csr(CSR_NODE_ID, CSR_DATA_W'(node));
      write_csr(CSR_RANGE_COUNT, CSR_DATA_W'(count));
      for (int i = 0; i < MAX_RANGES; i++)
         write_csr(CSR_INDEX_W'(CSR_RANGE_BASE + i), make_range());
   endtask

   task automatic queue_event(logic [FUNC_W-1:0] func, logic [CAN_ID_W-1:0] id,
                              logic [DATA_LEN_W-1:0] len, logic [PAYLOAD_W-1:0] data,
                              logic lost, logic [STATUS_W-1:0] sw);
      req_word_type w;
      w.func = func;
      w.can_id = id;
      w.data_len = len;
      w.payload = data;
      w.msg_lost = lost;
      w.status_word = sw;
      event_q.push_back(w);
   endtask

   task automatic queue_request(logic [REL_W-1:0] rel, logic [DATA_LEN_W-1:0] len,
                                logic [PAYLOAD_W-1:0] data, logic lost);
      queue_event(FUNC_REQUEST, CAN_ID_W'(node_base() + rel), len, data, lost,
                  STATUS_W'($urandom));
   endtask

   // request identifiers: mostly inside this node's window, aimed at live addresses
   function automatic logic [CAN_ID_W-1:0] random_request_id();
      logic [REL_W-1:0] rel, lo, hi;
      int unsigned pick, i;
      pick = $urandom_range(99);
      rel = REL_W'($urandom);
      if (pick >= 88) begin
         case ($urandom_range(2))
            0: return CAN_ID_W'(node_base() - 1 - $urandom_range(4095));
            1: return CAN_ID_W'(node_base() + WINDOW + $urandom_range(4095));
            default: return CAN_ID_W'($urandom);
         endcase
      end
      if (pick < 12) begin
         case ($urandom_range(5))
            0: rel = REL_SERIAL;
            1: rel = REL_PROTO_REV;
            2: rel = REL_ERR_COUNT;
            3: rel = REL_TXN_COUNT;
            4: rel = REL_SW_REV;
            default: rel = REL_HW_REV;
         endcase
      end else if (pick < 17) begin
         rel = $urandom_range(1) ? REL_RESET_A : REL_RESET_B;
      end else if (pick < 60) begin
         i = $urandom_range(MAX_RANGES - 1);
         lo = range_cfg[i][REL_W-1:0];
         hi = range_cfg[i][RANGE_W-1:REL_W];
         if (lo <= hi) rel = REL_W'($urandom_range(hi, lo));
      end
      return CAN_ID_W'(node_base() + rel);
   endfunction

   // allow_latch lets a bit error hit during identify mode and block the node for good
   task automatic queue_random_event(logic allow_latch);
      req_word_type w;
      int unsigned pick;
      w.can_id = CAN_ID_W'($urandom);
      w.data_len = DATA_LEN_W'($urandom);
      w.payload = {$urandom, $urandom};
      w.msg_lost = ($urandom_range(3) == 0);
      w.status_word = STATUS_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 5) begin
         w.func = FUNC_IDENTIFY;
      end else if (pick < 20) begin
         w.func = FUNC_STATUS;
         if (!allow_latch && w.status_word[ST_CODE_LSB +: ST_CODE_W] == CODE_BIT0)
            w.status_word[ST_TX_OK] = 1'b1;
      end else if (pick < 23) begin
         w.func = FUNC_UNUSED;
      end else begin
         w.func = FUNC_REQUEST;
         w.can_id = random_request_id();
         w.data_len = ($urandom_range(2) == 0) ? '0 : DATA_LEN_W'($urandom_range(15, 1));
      end
      event_q.push_back(w);
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (event_q.size() != 0 || events_in_flight != 0);
      repeat (4) @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      req_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || word_taken) begin
         if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            w = event_q.pop_front();
            events_in_flight++;
            req_if.func <= w.func;
            req_if.can_id <= w.can_id;
            req_if.data_len <= w.data_len;
            req_if.payload <= w.payload;
            req_if.msg_lost <= w.msg_lost;
            req_if.status_word <= w.status_word;
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response ready, with random stalls and a long hold-off in the first random phase
   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= (rsp_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (rsp_hold_left > 0) rsp_hold_left <= rsp_hold_left - 1;
   end

   // check responses against the oldest expectation, then predict the word taken now
   always @(posedge clock) begin
      rsp_word_type got, want;
      req_word_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.action = rsp_if.action;
         got.handler_index = rsp_if.handler_index;
         got.is_monitor = rsp_if.is_monitor;
         got.rel_address = rsp_if.rel_address;
         got.reply_id = rsp_if.reply_id;
         got.reply_len = rsp_if.reply_len;
         got.reply_data = rsp_if.reply_data;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch($sformatf("response with none expected: %h", got));
         end else begin
            want = expected_rsp_q.pop_front();
            events_in_flight--;
            check_field("action", got.action, want.action);
            check_field("handler_index", got.handler_index, want.handler_index);
            check_field("is_monitor", got.is_monitor, want.is_monitor);
            check_field("rel_address", got.rel_address, want.rel_address);
            check_field("reply_id", got.reply_id, want.reply_id);
            check_field("reply_len", got.reply_len, want.reply_len);
            check_field("reply_data", got.reply_data, want.reply_data);
         end
      end
      if (!reset && req_if.valid && req_if.ready) begin
         w.func = req_if.func;
         w.can_id = req_if.can_id;
         w.data_len = req_if.data_len;
         w.payload = req_if.payload;
         w.msg_lost = req_if.msg_lost;
         w.status_word = req_if.status_word;
         expected_rsp_q.push_back(predict_response(w));
      end
      word_taken <= !reset && req_if.valid && req_if.ready;
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.func = '0;
      req_if.can_id = '0;
      req_if.data_len = '0;
      req_if.payload = '0;
      req_if.msg_lost = 1'b0;
      req_if.status_word = '0;
      rsp_if.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      node_cfg = '0;
      range_count_cfg = '0;
      for (int i = 0; i < MAX_RANGES; i++) range_cfg[i] = '0;
      bus_errors = '0;
      txn_total = '0;
      identify_on = 1'b0;
      dup_latched = 1'b0;
      status_hi = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: overlapping ranges, an empty range, a range at the top address
      write_csr(CSR_NODE_ID, 5);
      write_csr(CSR_RANGE_COUNT, 4);
      write_csr(CSR_INDEX_W'(CSR_RANGE_BASE + 0), {18'h001ff, 18'h00100});
      write_csr(CSR_INDEX_W'(CSR_RANGE_BASE + 1), {18'h002ff, 18'h00150});
      write_csr(CSR_INDEX_W'(CSR_RANGE_BASE + 2), {18'h3ffff, 18'h3ffff});
      write_csr(CSR_INDEX_W'(CSR_RANGE_BASE + 3), {18'h00400, 18'h00500});
      write_csr(CSR_INDEX_W'(CSR_RANGE_BASE + 4), '0);
      write_csr(CSR_INDEX_W'(CSR_RANGE_BASE + 5), '1);

      queue_event(FUNC_IDENTIFY, '0, '0, '0, 1'b1, '0);
      queue_request(REL_SERIAL, 4'd0, '1, 1'b0);
      queue_request(REL_PROTO_REV, 4'd0, '0, 1'b0);
      queue_request(REL_SW_REV, 4'd0, '0, 1'b0);
      queue_request(REL_HW_REV, 4'd0, '0, 1'b0);
      queue_request(REL_ERR_COUNT, 4'd0, '0, 1'b0);
      queue_request(REL_TXN_COUNT, 4'd0, '0, 1'b0);
      queue_request(REL_RESET_A, 4'd8, '1, 1'b0);
      queue_request(REL_RESET_B, 4'd15, 64'h0123_4567_89ab_cdef, 1'b0);
      queue_request(REL_PROTO_REV, 4'd1, 64'h55, 1'b0);   // control write to a monitor point
      queue_request(18'h00100, 4'd0, '1, 1'b0);
      queue_request(18'h001ff, 4'd3, '1, 1'b0);
      queue_request(18'h00250, 4'd12, 64'hfedc_ba98_7654_3210, 1'b0);
      queue_request(18'h3ffff, 4'd8, '1, 1'b1);
      queue_request(18'h00450, 4'd1, '1, 1'b0);
      queue_request(18'h12345, 4'd2, '1, 1'b0);
      queue_event(FUNC_REQUEST, CAN_ID_W'(node_base() - 1), 4'd0, '0, 1'b0, '0);
      queue_event(FUNC_REQUEST, CAN_ID_W'(node_base() + WINDOW), 4'd0, '0, 1'b0, '0);
      queue_event(FUNC_REQUEST, '1, 4'd0, '0, 1'b0, '0);
      queue_event(FUNC_STATUS, '1, '1, '1, 1'b1, 16'hffff);
      queue_event(FUNC_STATUS, '0, '0, '0, 1'b0, 16'h0400);  // bit error, identify off
      queue_event(FUNC_STATUS, '0, '0, '0, 1'b0, 16'h0000);
      queue_event(FUNC_STATUS, '0, '0, '0, 1'b0, 16'h0600);
      queue_event(FUNC_UNUSED, CAN_ID_W'(node_base()), '0, '1, 1'b1, '1);
      queue_request(REL_ERR_COUNT, 4'd0, '0, 1'b0);
      queue_request(REL_TXN_COUNT, 4'd0, '0, 1'b0);
      wait_drained();

      // random phases; the sender holds back at each end until all responses are in
      for (int p = 0; p < NUM_PHASES; p++) begin
         configure(NODE_W'(PHASE_NODE[p]), RANGE_COUNT_W'(PHASE_COUNT[p]));
         send_idle_pct = SEND_IDLE[p % 4];
         recv_stall_pct = RECV_STALL[p % 4];
         if (p == 0) begin
            // long receiver hold-off while words keep coming
            @(posedge clock);
            rsp_hold_left <= 400;
         end
         repeat (WORDS_PER_PHASE) queue_random_event(1'b0);
         wait_drained();
      end

      // last phase: latch the duplicate address flag, requests are dropped afterwards
      configure(NODE_W'($urandom_range(63)), RANGE_COUNT_W'($urandom_range(7)));
      send_idle_pct = SEND_IDLE[3];
      recv_stall_pct = RECV_STALL[3];
      queue_event(FUNC_IDENTIFY, '0, '0, '0, 1'b0, '0);
      queue_event(FUNC_STATUS, '0, '0, '0, 1'b0, 16'h0400);
      repeat (60) queue_random_event(1'b1);
      wait_drained();
      repeat (10) @(negedge clock);

      if (expected_rsp_q.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_rsp_q.size()));
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("TIMEOUT");
      $display("Test completed with failures");
      $finish;
   end

endmodule
